>>> hdl/stereo_damped_feedback_delay_unit_defines.svh
`ifndef STEREO_DAMPED_FEEDBACK_DELAY_UNIT_DEFINES_SVH
`define STEREO_DAMPED_FEEDBACK_DELAY_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SDFD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SDFD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SDFD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define SDFD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> hdl/sdfd_pkg.sv
package sdfd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int DELAY_DEPTH_DEFAULT = 131072;
  localparam int CHANNELS_DEFAULT = 2;

  localparam int DELAY_W = 25;
  localparam int GAIN_W = 16;
  localparam int MIX_W = 17;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 25'd1228800;

  localparam logic signed [31:0] SAMPLE_MAX = 32'sd8388607;
  localparam logic signed [31:0] SAMPLE_MIN = -32'sd8388608;

  typedef enum logic [1:0] {
    REG_DELAY_LEFT  = 2'd0,
    REG_DELAY_RIGHT = 2'd1,
    REG_FEEDBACK    = 2'd2,
    REG_MIX         = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          channel;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          channel_out;
  } out_word_t;

  typedef struct packed {
    logic [DELAY_W-1:0] delay_left;
    logic [DELAY_W-1:0] delay_right;
    logic [GAIN_W-1:0]  feedback_gain;
    logic [MIX_W-1:0]   mix_amount;
  } cfg_t;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [31:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SAMPLE_MAX) begin
      r = SAMPLE_MAX[SAMPLE_BITS-1:0];
    end else if (v < SAMPLE_MIN) begin
      r = SAMPLE_MIN[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/sdfd_ram.sv
module sdfd_ram #(
  parameter int RAM_WIDTH = 24,
  parameter int RAM_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(RAM_DEPTH)-1:0] waddr,
  input  logic [RAM_WIDTH-1:0]         wdata,
  input  logic                         re,
  input  logic [$clog2(RAM_DEPTH)-1:0] raddr,
  output logic [RAM_WIDTH-1:0]         rdata
);

  logic [RAM_WIDTH-1:0] mem [RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/sdfd_cfg.sv
module sdfd_cfg
  import sdfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  reg_index_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_index_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_left    <= DELAY_RESET;
      cfg.delay_right   <= DELAY_RESET;
      cfg.feedback_gain <= '0;
      cfg.mix_amount    <= '0;
    end else if (wr_en) begin
      case (sel)
        REG_DELAY_LEFT:  cfg.delay_left    <= pwdata[DELAY_W-1:0];
        REG_DELAY_RIGHT: cfg.delay_right   <= pwdata[DELAY_W-1:0];
        REG_FEEDBACK:    cfg.feedback_gain <= pwdata[GAIN_W-1:0];
        REG_MIX:         cfg.mix_amount    <= pwdata[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_DELAY_LEFT:  prdata = PDATA_W'(cfg.delay_left);
      REG_DELAY_RIGHT: prdata = PDATA_W'(cfg.delay_right);
      REG_FEEDBACK:    prdata = PDATA_W'(cfg.feedback_gain);
      REG_MIX:         prdata = PDATA_W'(cfg.mix_amount);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> hdl/stereo_damped_feedback_delay_unit.sv
// result word registered at the write-back, which follows states S_RD1 and S_INT
// the write-back waits while the output stalls; no new word is taken until it is done
// (the single read port of the delay memory serves the two interpolation reads in turn)
// reset: synchronous, clears control registers, write positions, wrap flags and damping states
// never-written delay entries read as zero through per-channel fill tracking, no clearing pass
`include "stereo_damped_feedback_delay_unit_defines.svh"

module stereo_damped_feedback_delay_unit
  import sdfd_pkg::*;
#(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEFAULT,
  parameter int CHANNELS    = CHANNELS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  in_word_t           sample_word,
  output logic               result_valid,
  input  logic               result_stall,
  output out_word_t          result_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int PW  = AW + 8;
  localparam int RAW = $clog2(CHANNELS * DELAY_DEPTH);
  localparam logic [RAW-1:0] CH_OFFSET = RAW'(DELAY_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD1  = 4'b0010,
    S_INT  = 4'b0100,
    S_WR   = 4'b1000
  } state_t;

  state_t state, state_next;
  cfg_t   cfg;

  logic [AW-1:0]                 wp [CHANNELS];
  logic                          wrap [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] damp [CHANNELS];

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic                          ch_r;
  logic                          tag_r;
  logic [AW-1:0]                 wp_r;
  logic                          wrap_r;
  logic [AW-1:0]                 nxt_r;
  logic [7:0]                    f_r;
  logic                          rd_ok;
  logic signed [SAMPLE_BITS-1:0] s0_r;
  logic signed [SAMPLE_BITS-1:0] z_r;

  logic                          accept;
  logic                          out_free;
  logic                          ch_in;
  logic [DELAY_W-1:0]            d_sel;
  logic [PW-1:0]                 pos;
  logic [AW-1:0]                 idx;
  logic [AW-1:0]                 wp_in;
  logic                          idx_ok;

  logic                          ram_we;
  logic                          ram_re;
  logic [RAW-1:0]                ram_raddr;
  logic [RAW-1:0]                ram_waddr;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic signed [SAMPLE_BITS-1:0] ram_wdata;
  logic signed [SAMPLE_BITS-1:0] rd_val;

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [33:0]            acc;
  logic signed [SAMPLE_BITS-1:0] delayed;
  logic signed [SAMPLE_BITS:0]   zsum;

  logic signed [40:0]            fbp;
  logic signed [SAMPLE_BITS:0]   stsum;
  logic signed [17:0]            dry;
  logic signed [17:0]            wet;
  logic signed [41:0]            p_dry;
  logic signed [41:0]            p_wet;
  logic signed [42:0]            msum;

  sdfd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sdfd_ram #(
    .RAM_WIDTH (SAMPLE_BITS),
    .RAM_DEPTH (CHANNELS * DELAY_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign out_free     = !result_valid || !result_stall;

  // read position from write position and fractional delay
  assign ch_in  = (CHANNELS > 1) ? sample_word.channel : 1'b0;
  assign d_sel  = sample_word.channel ? cfg.delay_right : cfg.delay_left;
  assign wp_in  = wp[ch_in];
  assign pos    = {wp_in, 8'd0} - PW'(d_sel);
  assign idx    = pos[PW-1:8];
  assign idx_ok = wrap[ch_in] || (idx < wp_in);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = RAW'(idx) | (ch_in ? CH_OFFSET : '0);
    if (state == S_IDLE) begin
      ram_re = accept;
    end else if (state == S_RD1) begin
      ram_re    = 1'b1;
      ram_raddr = RAW'(nxt_r) | (ch_r ? CH_OFFSET : '0);
    end
  end

  assign rd_val = rd_ok ? $signed(ram_rdata) : '0;

  // linear interpolation and damping
  assign diff    = (SAMPLE_BITS+1)'(rd_val) - (SAMPLE_BITS+1)'(s0_r);
  assign acc     = $signed({{2{s0_r[SAMPLE_BITS-1]}}, s0_r, 8'd0}) + diff * $signed({1'b0, f_r});
  assign delayed = acc[31:8];
  assign zsum    = (SAMPLE_BITS+1)'(damp[ch_r]) + (SAMPLE_BITS+1)'(delayed);

  // feedback write-back and dry/wet mix
  assign fbp       = z_r * $signed({1'b0, cfg.feedback_gain});
  assign stsum     = (SAMPLE_BITS+1)'(x_r) + (SAMPLE_BITS+1)'($signed(fbp[39:16]));
  assign ram_wdata = sat_sample(32'(stsum));
  assign wet       = $signed({1'b0, cfg.mix_amount});
  assign dry       = 18'sh10000 - wet;
  assign p_dry     = x_r * dry;
  assign p_wet     = z_r * wet;
  assign msum      = 43'(p_dry) + 43'(p_wet);

  assign ram_we    = (state == S_WR) && out_free;
  assign ram_waddr = RAW'(wp_r) | (ch_r ? CH_OFFSET : '0);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_RD1;
      S_RD1:   state_next = S_INT;
      S_INT:   state_next = S_WR;
      S_WR:    if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= sample_word.sample_in;
      ch_r   <= ch_in;
      tag_r  <= sample_word.channel;
      wp_r   <= wp_in;
      wrap_r <= wrap[ch_in];
      nxt_r  <= idx + AW'(1);
      f_r    <= pos[7:0];
      rd_ok  <= idx_ok;
    end else if (state == S_RD1) begin
      s0_r  <= rd_val;
      rd_ok <= wrap_r || (nxt_r < wp_r);
    end
    if (state == S_INT) begin
      z_r <= zsum[SAMPLE_BITS:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wp[i]   <= '0;
        wrap[i] <= 1'b0;
        damp[i] <= '0;
      end
    end else if (ram_we) begin
      wp[ch_r]   <= wp_r + AW'(1);
      damp[ch_r] <= z_r;
      if (wp_r == '1) begin
        wrap[ch_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ram_we) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      result_word.sample_out  <= sat_sample({{5{msum[42]}}, msum[42:16]});
      result_word.channel_out <= tag_r;
    end
  end

  `SDFD_ASSERT_IMP(a_no_rw_overlap, clk, rst, ram_we, !ram_re, "delay memory read and write overlap")
  `SDFD_ASSERT_NXT(a_word_after_write, clk, rst, ram_we, result_valid && state == S_IDLE, "no result word after write-back")
  `SDFD_ASSERT_IMP(a_word_from_write, clk, rst, $rose(result_valid), $past(ram_we), "result word without write-back")

endmodule
